>>> design/rau_pkg.sv
`default_nettype none
package rau_pkg;

  localparam int unsigned DefaultWidth = 32;
  localparam int unsigned FieldWidth   = 32;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_SIMP = 3'd4,
    CMD_EQ  = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [2:0]            cmd;
    logic signed [FieldWidth-1:0] a_num;
    logic signed [FieldWidth-1:0] a_den;
    logic signed [FieldWidth-1:0] b_num;
    logic signed [FieldWidth-1:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] res_num;
    logic signed [FieldWidth-1:0] res_den;
    logic                  is_equal;
    logic                  gcd_zero;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_MUL,
    OP_GCD,
    OP_DIV
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_MUL_WAIT,
    ST_GCD_A,
    ST_GCD_A_WAIT,
    ST_DIV_A,
    ST_DIV_A_WAIT,
    ST_GCD_B,
    ST_GCD_B_WAIT,
    ST_DIV_B,
    ST_DIV_B_WAIT,
    ST_DONE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic   start;
    dp_op_e op;
    logic   sel_b;
    logic   finish;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic gcd_zero;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> design/rational_arithmetic_unit.sv
// rational arithmetic unit: add, subtract, multiply, divide, simplify and
// equality on two fractions a = a_num/a_den and b = b_num/b_den.
// input channel in_valid/in_ready/in_data carries cmd and the four fields;
// output channel out_valid/out_ready/out_data carries res_num, res_den,
// is_equal and gcd_zero. one result for every input transfer.
// add, subtract, multiply and divide go through one multiply stage.
// simplify runs euclid on a shared restoring divider, one quotient bit
// per cycle, one division per remainder; reducing then takes two more
// divisions, and equality reduces both a and b. one item is in flight at
// a time: in_ready is high only when idle and the result has been taken.
// a zero gcd sets gcd_zero and passes the fraction through unreduced.
// if the receiver stalls, the result holds on out_data with out_valid high.
// after the synchronous reset the block is idle and ready at once.
`default_nettype none
module rational_arithmetic_unit #(
  parameter int unsigned WIDTH = rau_pkg::DefaultWidth
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rau_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rau_pkg::out_item_t       out_data
);
  import rau_pkg::*;

  logic     load;
  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_data.cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (dstat),
    .load      (load),
    .cmd       (dcmd)
  );

  rau_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .in_data (in_data),
    .cmd     (dcmd),
    .stat    (dstat),
    .result  (out_data)
  );

endmodule
`default_nettype wire

>>> design/rau_divider.sv
`default_nettype none
module rau_divider #(
  parameter int unsigned WIDTH = rau_pkg::DefaultWidth
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic                  busy,
  output logic [WIDTH-1:0]      quot,
  output logic [WIDTH-1:0]      rem
);
  import rau_pkg::*;

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic             busy_r, busy_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] q_r, q_nxt;
  logic [WIDTH-1:0] r_r, r_nxt;
  logic [WIDTH-1:0] d_r, d_nxt;
  logic             qneg_r, qneg_nxt;
  logic             rneg_r, rneg_nxt;
  logic [WIDTH:0]   trial;

  // unsigned restoring division on magnitudes, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    trial    = '0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(WIDTH);
      q_nxt    = dividend[WIDTH-1] ? -dividend : dividend;
      d_nxt    = divisor[WIDTH-1] ? -divisor : divisor;
      r_nxt    = '0;
      qneg_nxt = dividend[WIDTH-1] ^ divisor[WIDTH-1];
      rneg_nxt = dividend[WIDTH-1];
    end else if (busy_r) begin
      trial = {r_r, q_r[WIDTH-1]} - {1'b0, d_r};
      if (!trial[WIDTH]) begin
        r_nxt = trial[WIDTH-1:0];
        q_nxt = {q_r[WIDTH-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[WIDTH-2:0], q_r[WIDTH-1]};
        q_nxt = {q_r[WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r    <= q_nxt;
    r_r    <= r_nxt;
    d_r    <= d_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  assign busy = busy_r;
  assign quot = qneg_r ? -q_r : q_r;
  assign rem  = rneg_r ? -r_r : r_r;

endmodule
`default_nettype wire

>>> design/rau_datapath.sv
`default_nettype none
module rau_datapath #(
  parameter int unsigned WIDTH = rau_pkg::DefaultWidth
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire rau_pkg::in_item_t   in_data,
  input  wire rau_pkg::dp_cmd_t    cmd,
  output rau_pkg::dp_stat_t        stat,
  output rau_pkg::out_item_t       result
);
  import rau_pkg::*;

  logic [WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic [2:0]       op_r;
  logic [WIDTH-1:0] m_r, n_r;
  logic [WIDTH-1:0] g_r;
  logic             phase_r;
  logic             gz_r;
  logic             dbusy_r;
  logic             mbusy_r;
  logic [WIDTH-1:0] p0_r, p1_r, p2_r, p3_r;
  logic [WIDTH-1:0] rn_r, rd_r;
  logic             eq_r;

  logic             div_start;
  logic [WIDTH-1:0] div_a, div_b;
  logic             div_busy;
  logic [WIDTH-1:0] div_q, div_r;
  logic [WIDTH-1:0] src_num, src_den;

  function automatic logic [WIDTH-1:0] ext(input logic [FieldWidth-1:0] v);
    logic [WIDTH+FieldWidth-1:0] t;
    t = {{WIDTH{v[FieldWidth-1]}}, v};
    return t[WIDTH-1:0];
  endfunction

  function automatic logic [FieldWidth-1:0] outw(input logic [WIDTH-1:0] v);
    logic [WIDTH+FieldWidth-1:0] t;
    t = {{FieldWidth{v[WIDTH-1]}}, v};
    return t[FieldWidth-1:0];
  endfunction

  assign src_num = cmd.sel_b ? bn_r : an_r;
  assign src_den = cmd.sel_b ? bd_r : ad_r;

  rau_divider #(.WIDTH(WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quot     (div_q),
    .rem      (div_r)
  );

  // gcd loop: m rem n on the shared divider; reduce: num/g then den/g
  always_comb begin
    div_start = 1'b0;
    div_a     = m_r;
    div_b     = n_r;
    if (cmd.start && cmd.op == OP_DIV) begin
      div_start = g_r != '0;
      div_a     = src_num;
      div_b     = g_r;
    end else if (dbusy_r && !div_busy && cmd.op == OP_DIV && !phase_r) begin
      div_start = 1'b1;
      div_a     = src_den;
      div_b     = g_r;
    end else if (cmd.start && cmd.op == OP_GCD) begin
      div_start = src_den != '0;
      div_a     = src_num;
      div_b     = src_den;
    end else if (dbusy_r && !div_busy && cmd.op == OP_GCD) begin
      div_start = div_r != '0;
      div_a     = n_r;
      div_b     = div_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      mbusy_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      mbusy_r <= cmd.start && cmd.op == OP_MUL;
      if (cmd.start) begin
        unique case (cmd.op)
          OP_MUL: begin
          end
          OP_GCD: begin
            dbusy_r <= src_den != '0;
          end
          OP_DIV: begin
            dbusy_r <= g_r != '0;
            phase_r <= 1'b0;
          end
          default: begin
            dbusy_r <= 1'b0;
          end
        endcase
      end else if (dbusy_r && !div_busy) begin
        if (cmd.op == OP_GCD) begin
          dbusy_r <= div_r != '0;
        end else if (!phase_r) begin
          phase_r <= 1'b1;
        end else begin
          dbusy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_r <= in_data.cmd;
      an_r <= ext(in_data.a_num);
      ad_r <= ext(in_data.a_den);
      bn_r <= ext(in_data.b_num);
      bd_r <= ext(in_data.b_den);
      gz_r <= 1'b0;
    end
    if (cmd.start && cmd.op == OP_MUL) begin
      unique case (op_r)
        CMD_MUL: begin
          p0_r <= an_r * bn_r;
          p1_r <= '0;
        end
        CMD_DIV: begin
          p0_r <= an_r * bd_r;
          p1_r <= '0;
        end
        default: begin
          p0_r <= an_r * bd_r;
          p1_r <= ad_r * bn_r;
        end
      endcase
      p2_r <= ad_r * bd_r;
      p3_r <= ad_r * bn_r;
    end
    if (cmd.start && cmd.op == OP_GCD) begin
      m_r <= src_num;
      n_r <= src_den;
      g_r <= src_num;
    end else if (dbusy_r && !div_busy && cmd.op == OP_GCD) begin
      m_r <= n_r;
      n_r <= div_r;
      g_r <= n_r;
    end
    if (cmd.start && cmd.op == OP_DIV && g_r == '0) begin
      gz_r <= 1'b1;
    end
    if (dbusy_r && !div_busy && cmd.op == OP_DIV) begin
      if (!phase_r) begin
        if (cmd.sel_b) bn_r <= div_q;
        else an_r <= div_q;
      end else begin
        if (cmd.sel_b) bd_r <= div_q;
        else ad_r <= div_q;
      end
    end
    if (cmd.finish) begin
      unique case (op_r)
        CMD_ADD: begin
          rn_r <= p0_r + p1_r;
          rd_r <= p2_r;
          eq_r <= 1'b0;
        end
        CMD_SUB: begin
          rn_r <= p0_r - p1_r;
          rd_r <= p2_r;
          eq_r <= 1'b0;
        end
        CMD_MUL: begin
          rn_r <= p0_r;
          rd_r <= p2_r;
          eq_r <= 1'b0;
        end
        CMD_DIV: begin
          rn_r <= p0_r;
          rd_r <= p3_r;
          eq_r <= 1'b0;
        end
        CMD_SIMP: begin
          rn_r <= an_r;
          rd_r <= ad_r;
          eq_r <= 1'b0;
        end
        CMD_EQ: begin
          rn_r <= '0;
          rd_r <= '0;
          eq_r <= an_r == bn_r && ad_r == bd_r;
        end
        default: begin
          rn_r <= '0;
          rd_r <= '0;
          eq_r <= 1'b0;
        end
      endcase
    end
  end

  assign stat.busy     = dbusy_r | mbusy_r | div_busy;
  assign stat.gcd_zero = gz_r;

  assign result.res_num  = outw(rn_r);
  assign result.res_den  = outw(rd_r);
  assign result.is_equal = eq_r;
  assign result.gcd_zero = gz_r & (op_r == CMD_SIMP || op_r == CMD_EQ);

endmodule
`default_nettype wire

>>> design/rau_ctrl.sv
`default_nettype none
module rau_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_cmd,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire rau_pkg::dp_stat_t  stat,
  output logic                    load,
  output rau_pkg::dp_cmd_t        cmd
);
  import rau_pkg::*;

  state_e     state_r, state_nxt;
  logic [2:0] op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (load) begin
      op_r <= in_cmd;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    load       = 1'b0;
    cmd        = '{start: 1'b0, op: OP_LOAD, sel_b: 1'b0, finish: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          load = 1'b1;
          state_nxt = (in_cmd == CMD_SIMP || in_cmd == CMD_EQ) ? ST_GCD_A : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.start = 1'b1;
        cmd.op    = OP_MUL;
        state_nxt = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        cmd.op    = OP_MUL;
        state_nxt = ST_DONE;
      end
      ST_GCD_A: begin
        cmd.start = 1'b1;
        cmd.op    = OP_GCD;
        state_nxt = ST_GCD_A_WAIT;
      end
      ST_GCD_A_WAIT: begin
        cmd.op = OP_GCD;
        if (!stat.busy) state_nxt = ST_DIV_A;
      end
      ST_DIV_A: begin
        cmd.start = 1'b1;
        cmd.op    = OP_DIV;
        state_nxt = ST_DIV_A_WAIT;
      end
      ST_DIV_A_WAIT: begin
        cmd.op = OP_DIV;
        if (!stat.busy) state_nxt = (op_r == CMD_EQ) ? ST_GCD_B : ST_DONE;
      end
      ST_GCD_B: begin
        cmd.start = 1'b1;
        cmd.op    = OP_GCD;
        cmd.sel_b = 1'b1;
        state_nxt = ST_GCD_B_WAIT;
      end
      ST_GCD_B_WAIT: begin
        cmd.op    = OP_GCD;
        cmd.sel_b = 1'b1;
        if (!stat.busy) state_nxt = ST_DIV_B;
      end
      ST_DIV_B: begin
        cmd.start = 1'b1;
        cmd.op    = OP_DIV;
        cmd.sel_b = 1'b1;
        state_nxt = ST_DIV_B_WAIT;
      end
      ST_DIV_B_WAIT: begin
        cmd.op    = OP_DIV;
        cmd.sel_b = 1'b1;
        if (!stat.busy) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import rau_pkg::*;

  localparam int NumRandom = 1630;
  localparam int StallLimit = 40000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  rational_arithmetic_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  out_item_t pending_results[$];
  int mismatches;
  int results_seen;
  int idle_cycles;
  int cmd_count[8];
  bit stim_done;

  typedef struct {
    in_item_t stim;
    bit has_fixed;
    out_item_t fixed;
  } dir_row_t;

  function automatic logic signed [31:0] sdiv(logic signed [31:0] x, logic signed [31:0] y);
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] q;
    ax = x[31] ? -x : x;
    ay = y[31] ? -y : y;
    q = ax / ay;
    return (x[31] != y[31]) ? -q : q;
  endfunction

  function automatic logic signed [31:0] srem(logic signed [31:0] x, logic signed [31:0] y);
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] r;
    ax = x[31] ? -x : x;
    ay = y[31] ? -y : y;
    r = ax % ay;
    return x[31] ? -r : r;
  endfunction

  function automatic bit reduce_frac(inout logic signed [31:0] num,
                                     inout logic signed [31:0] den);
    logic signed [31:0] m;
    logic signed [31:0] n;
    logic signed [31:0] t;
    m = num;
    n = den;
    while (n != 0) begin
      t = srem(m, n);
      m = n;
      n = t;
    end
    if (m == 0) return 1'b1;
    num = sdiv(num, m);
    den = sdiv(den, m);
    return 1'b0;
  endfunction

  function automatic out_item_t rational_result(in_item_t it);
    out_item_t r;
    logic signed [31:0] an, ad, bn, bd;
    bit za, zb;
    r = '0;
    an = it.a_num; ad = it.a_den; bn = it.b_num; bd = it.b_den;
    case (it.cmd)
      CMD_ADD: begin
        r.res_num = an * bd + ad * bn;
        r.res_den = ad * bd;
      end
      CMD_SUB: begin
        r.res_num = an * bd - ad * bn;
        r.res_den = ad * bd;
      end
      CMD_MUL: begin
        r.res_num = an * bn;
        r.res_den = ad * bd;
      end
      CMD_DIV: begin
        r.res_num = an * bd;
        r.res_den = ad * bn;
      end
      CMD_SIMP: begin
        r.gcd_zero = reduce_frac(an, ad);
        r.res_num = an;
        r.res_den = ad;
      end
      CMD_EQ: begin
        za = reduce_frac(an, ad);
        zb = reduce_frac(bn, bd);
        r.gcd_zero = za | zb;
        r.is_equal = (an == bn) && (ad == bd);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      4, 5: return $urandom_range(0, 40) - 20;
      6, 7: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_cmd();
    case ($urandom_range(0, 19))
      0: return 3'd6;
      1: return 3'd7;
      2, 3, 4, 5, 6, 7: return CMD_SIMP;
      8, 9, 10, 11, 12: return CMD_EQ;
      default: return 3'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 120);
    return $urandom_range(1, 4);
  endfunction

  task automatic send_item(in_item_t it, bit has_fixed, out_item_t fixed);
    out_item_t want;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    want = has_fixed ? fixed : rational_result(it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(want);
    cmd_count[it.cmd]++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", out_data.res_num, 32'h0);
      end else begin
        out_item_t want;
        want = pending_results.pop_front();
        if (out_data.res_num !== want.res_num)
          report_mismatch("res_num", out_data.res_num, want.res_num);
        if (out_data.res_den !== want.res_den)
          report_mismatch("res_den", out_data.res_den, want.res_den);
        if (out_data.is_equal !== want.is_equal)
          report_mismatch("is_equal", out_data.is_equal, want.is_equal);
        if (out_data.gcd_zero !== want.gcd_zero)
          report_mismatch("gcd_zero", out_data.gcd_zero, want.gcd_zero);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 3) != 0) begin
      out_ready <= 1'b1;
    end else begin
      gap = $urandom_range(0, 9) == 0 ? 60 : 3;
      out_ready <= ($urandom_range(0, gap) == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog expired, %0d results outstanding", pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic dir_row_t mk(logic [2:0] c, logic [31:0] an, logic [31:0] ad,
                                  logic [31:0] bn, logic [31:0] bd, bit fx,
                                  logic [31:0] rn, logic [31:0] rd, bit eq, bit gz);
    dir_row_t row;
    row.stim = '{cmd: c, a_num: an, a_den: ad, b_num: bn, b_den: bd};
    row.has_fixed = fx;
    row.fixed = '{res_num: rn, res_den: rd, is_equal: eq, gcd_zero: gz};
    return row;
  endfunction

  dir_row_t directed[$];

  initial begin
    in_item_t it;
    mismatches = 0;
    results_seen = 0;
    idle_cycles = 0;
    stim_done = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(mk(CMD_ADD, 1, 2, 1, 3, 1, 5, 6, 0, 0));
    directed.push_back(mk(CMD_SUB, 1, 2, 1, 3, 1, 1, 6, 0, 0));
    directed.push_back(mk(CMD_MUL, 2, 3, 5, 7, 1, 10, 21, 0, 0));
    directed.push_back(mk(CMD_DIV, 2, 3, 5, 7, 1, 14, 15, 0, 0));
    directed.push_back(mk(CMD_SIMP, 4, -6, 0, 0, 1, -2, 3, 0, 0));
    directed.push_back(mk(CMD_SIMP, 0, 0, 9, 9, 1, 0, 0, 0, 1));
    directed.push_back(mk(CMD_SIMP, 6, 4, 0, 0, 1, 3, 2, 0, 0));
    directed.push_back(mk(CMD_SIMP, 0, 5, 0, 0, 1, 0, 1, 0, 0));
    directed.push_back(mk(CMD_SIMP, 5, 0, 0, 0, 1, 1, 0, 0, 0));
    directed.push_back(mk(CMD_EQ, 1, 2, 2, 4, 1, 0, 0, 1, 0));
    directed.push_back(mk(CMD_EQ, 1, 2, 1, 3, 1, 0, 0, 0, 0));
    directed.push_back(mk(CMD_EQ, 0, 0, 0, 0, 1, 0, 0, 1, 1));
    directed.push_back(mk(CMD_EQ, 0, 0, 1, 2, 1, 0, 0, 0, 1));
    directed.push_back(mk(3'd6, 7, 7, 7, 7, 1, 0, 0, 0, 0));
    directed.push_back(mk(3'd7, -1, -1, -1, -1, 1, 0, 0, 0, 0));
    directed.push_back(mk(CMD_SIMP, 32'h8000_0000, -1, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(CMD_SIMP, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(CMD_SIMP, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(CMD_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                          32'hffff_ffff, 0, 0, 0, 0, 0));
    directed.push_back(mk(CMD_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                          32'h8000_0000, 0, 0, 0, 0, 0));
    directed.push_back(mk(CMD_EQ, 32'h8000_0000, -1, 32'h8000_0000, 1, 0, 0, 0, 0, 0));
    directed.push_back(mk(CMD_EQ, -3, 6, 1, -2, 0, 0, 0, 0, 0));

    foreach (directed[i]) send_item(directed[i].stim, directed[i].has_fixed, directed[i].fixed);

    for (int n = 0; n < NumRandom; n++) begin
      it.cmd = pick_cmd();
      it.a_num = pick_value();
      it.a_den = pick_value();
      it.b_num = pick_value();
      it.b_den = pick_value();
      if (it.cmd == CMD_EQ && $urandom_range(0, 2) == 0) begin
        int k;
        k = $urandom_range(1, 50) * (($urandom_range(0, 1) != 0) ? 1 : -1);
        it.a_num = $urandom_range(0, 200) - 100;
        it.a_den = $urandom_range(0, 200) - 100;
        it.b_num = it.a_num * k;
        it.b_den = it.a_den * k;
      end
      send_item(it, 1'b0, '0);
    end
    in_valid <= 1'b0;
    stim_done = 1;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);

    $display("%0d results checked: add %0d sub %0d mul %0d div %0d simp %0d eq %0d unused %0d",
             results_seen, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3],
             cmd_count[4], cmd_count[5], cmd_count[6] + cmd_count[7]);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
